FILE: hw/rtl/ctit_pkg.sv
package ctit_pkg;

  localparam int unsigned TableDepth = 32;
  // the index fields are 5 bits wide, so no more than this many entries are ever used
  localparam int unsigned MaxUsed    = 32;

  localparam logic [2:0] CmdAdd     = 3'd0;
  localparam logic [2:0] CmdDelete  = 3'd1;
  localparam logic [2:0] CmdSetSend = 3'd2;
  localparam logic [2:0] CmdSetRecv = 3'd3;
  localparam logic [2:0] CmdClose   = 3'd4;
  localparam logic [2:0] CmdTick    = 3'd5;

  localparam logic [1:0] KindReply   = 2'd0;
  localparam logic [1:0] KindSendExp = 2'd1;
  localparam logic [1:0] KindRecvExp = 2'd2;
  localparam logic [1:0] KindSummary = 2'd3;

  localparam logic [29:0] SessionTop = 30'd999999999;
  localparam logic [5:0]  ActiveRst  = 6'd32;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] socket_id;
    logic [29:0] session_id;
    logic [4:0]  entry_index;
    logic        check_send;
    logic        check_receive;
    logic [15:0] send_timeout;
    logic [15:0] receive_timeout;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [4:0]  result_index;
    logic [29:0] result_session;
    logic [31:0] result_socket;
    logic [5:0]  alive_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] socket;
    logic [29:0] session;
    logic        chk_send;
    logic        chk_recv;
    logic [15:0] send_lim;
    logic [15:0] recv_lim;
    logic [31:0] last_send;
    logic [31:0] last_recv;
  } entry_t;

endpackage

FILE: hw/rtl/ctit_ram.sv
module ctit_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ctit_out_reg.sv
module ctit_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctit_pkg::out_t    data_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ctit_pkg::out_t    out_data_o
);

  logic           valid_q, valid_d;
  ctit_pkg::out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: hw/rtl/connection_idle_timeout_table_unit.sv
// Rejected commands reply from StReply, addressed commands from StExec after the record read;
// add scans alive flags one entry a cycle and replies from the first free entry or the end.
// Tick: one entry a cycle through the record memory read port while no expiry result is
// held up by a full output register, then a summary. One item in flight at a time.
// Reset: all entries free, seconds clock 0, next session 1, 32 entries in use.
// The record memory is not cleared; alive flags in flip-flops gate every use of a read record.
module connection_idle_timeout_table_unit #(
  parameter int unsigned TABLE_DEPTH = ctit_pkg::TableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctit_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ctit_pkg::out_t    out_data_o,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_data_i
);

  localparam int unsigned DepthUsed =
    (TABLE_DEPTH < ctit_pkg::MaxUsed) ? TABLE_DEPTH : ctit_pkg::MaxUsed;
  localparam int unsigned AddrW = $clog2(DepthUsed);
  localparam int unsigned RecW  = $bits(ctit_pkg::entry_t);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StScan  = 5'b00010,
    StSweep = 5'b00100,
    StExec  = 5'b01000,
    StReply = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [5:0]          active_q;
  logic [5:0]          ptr_q, ptr_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]    chk_idx_q, chk_idx_d;
  logic [DepthUsed-1:0] alive_q, alive_d;
  logic [29:0]         session_q, session_d;
  logic [31:0]         seconds_q, seconds_d;
  ctit_pkg::in_t       item_q, item_d;

  logic [5:0]          used_len;
  logic [AddrW-1:0]    pidx;
  logic [AddrW-1:0]    eidx;
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  ctit_pkg::entry_t    ram_wdata, rd;
  logic [RecW-1:0]     ram_rdata;
  logic                out_push, out_free;
  ctit_pkg::out_t      res;
  logic                match;
  logic [31:0]         send_idle, recv_idle;
  logic                send_exp, recv_exp, hit, stall;

  assign used_len = (active_q > 6'(DepthUsed)) ? 6'(DepthUsed) : active_q;
  assign pidx     = ptr_q[AddrW-1:0];
  assign eidx     = item_q.entry_index[AddrW-1:0];
  assign rd       = ctit_pkg::entry_t'(ram_rdata);

  assign match = alive_q[eidx] && (rd.socket == item_q.socket_id) &&
                 (item_q.session_id != 30'd0) && (rd.session == item_q.session_id);

  // idle time wraps modulo 2^32
  assign send_idle = seconds_q - rd.last_send;
  assign recv_idle = seconds_q - rd.last_recv;
  assign send_exp  = rd.chk_send && (send_idle > {16'd0, rd.send_lim});
  assign recv_exp  = rd.chk_recv && (recv_idle > {16'd0, rd.recv_lim});
  assign hit       = chk_vld_q && (send_exp || recv_exp);
  assign stall     = hit && !out_free;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    alive_d   = alive_q;
    session_d = session_q;
    seconds_d = seconds_q;
    item_d    = item_q;
    ram_we    = 1'b0;
    ram_waddr = eidx;
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = pidx;
    out_push  = 1'b0;
    res                = '0;
    res.kind           = ctit_pkg::KindReply;
    res.result_socket  = item_q.socket_id;
    res.last           = 1'b1;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          priority if (in_data_i.cmd == ctit_pkg::CmdAdd) begin
            ptr_d   = '0;
            state_d = StScan;
          end else if (in_data_i.cmd == ctit_pkg::CmdTick) begin
            seconds_d = seconds_q + 32'd1;
            ptr_d     = '0;
            cnt_d     = '0;
            chk_vld_d = 1'b0;
            state_d   = StSweep;
          end else if (in_data_i.cmd > ctit_pkg::CmdTick ||
                       {1'b0, in_data_i.entry_index} >= used_len) begin
            state_d = StReply;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_data_i.entry_index[AddrW-1:0];
            state_d   = StExec;
          end
        end
      end

      StScan: begin
        if (ptr_q >= used_len) begin
          res.status = 1'b1;
          if (out_free) begin
            out_push = 1'b1;
            state_d  = StIdle;
          end
        end else if (!alive_q[pidx]) begin
          res.result_index   = 5'(ptr_q);
          res.result_session = session_q;
          if (out_free) begin
            out_push           = 1'b1;
            alive_d[pidx]      = 1'b1;
            session_d          = (session_q > ctit_pkg::SessionTop) ? 30'd1 : session_q + 30'd1;
            ram_we             = 1'b1;
            ram_waddr          = pidx;
            ram_wdata.socket   = item_q.socket_id;
            ram_wdata.session  = session_q;
            ram_wdata.chk_send = item_q.check_send;
            ram_wdata.chk_recv = item_q.check_receive;
            ram_wdata.send_lim = item_q.send_timeout;
            ram_wdata.recv_lim = item_q.receive_timeout;
            ram_wdata.last_send = seconds_q;
            ram_wdata.last_recv = seconds_q;
            state_d            = StIdle;
          end
        end else begin
          ptr_d = ptr_q + 6'd1;
        end
      end

      StSweep: begin
        if (hit) begin
          res.kind           = send_exp ? ctit_pkg::KindSendExp : ctit_pkg::KindRecvExp;
          res.result_index   = 5'(chk_idx_q);
          res.result_session = rd.session;
          res.result_socket  = rd.socket;
          res.last           = 1'b0;
          if (out_free) begin
            out_push           = 1'b1;
            alive_d[chk_idx_q] = 1'b0;
          end
        end
        // read of the next entry overlaps the check of the current one
        if (!stall) begin
          if (ptr_q < used_len) begin
            chk_vld_d = alive_q[pidx];
            chk_idx_d = pidx;
            ram_re    = alive_q[pidx];
            cnt_d     = cnt_q + 6'(alive_q[pidx]);
            ptr_d     = ptr_q + 6'd1;
          end else begin
            chk_vld_d = 1'b0;
            if (!chk_vld_q) begin
              res.kind        = ctit_pkg::KindSummary;
              res.alive_count = cnt_q;
              if (out_free) begin
                out_push = 1'b1;
                state_d  = StIdle;
              end
            end
          end
        end
      end

      StExec: begin
        ram_wdata = rd;
        unique case (item_q.cmd)
          ctit_pkg::CmdClose: begin
            res.status = 1'b0;
          end
          ctit_pkg::CmdDelete: begin
            res.status = !match;
          end
          ctit_pkg::CmdSetSend: begin
            res.status         = !match;
            ram_wdata.chk_send = item_q.check_send;
            if (item_q.check_send) begin
              ram_wdata.last_send = seconds_q;
              ram_wdata.send_lim  = item_q.send_timeout;
            end
          end
          ctit_pkg::CmdSetRecv: begin
            res.status         = !match;
            ram_wdata.chk_recv = item_q.check_receive;
            if (item_q.check_receive) begin
              ram_wdata.last_recv = seconds_q;
              ram_wdata.recv_lim  = item_q.receive_timeout;
            end
          end
          default: begin
            res.status = 1'b1;
          end
        endcase
        if (out_free) begin
          out_push = 1'b1;
          state_d  = StIdle;
          if (match) begin
            if (item_q.cmd == ctit_pkg::CmdClose || item_q.cmd == ctit_pkg::CmdDelete) begin
              alive_d[eidx] = 1'b0;
            end else if (item_q.cmd == ctit_pkg::CmdSetSend ||
                         item_q.cmd == ctit_pkg::CmdSetRecv) begin
              ram_we = 1'b1;
            end
          end
        end
      end

      StReply: begin
        res.status = 1'b1;
        if (out_free) begin
          out_push = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      active_q  <= ctit_pkg::ActiveRst;
      ptr_q     <= '0;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      alive_q   <= '0;
      session_q <= 30'd1;
      seconds_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      alive_q   <= alive_d;
      session_q <= session_d;
      seconds_q <= seconds_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  ctit_ram #(
    .Width (RecW),
    .Depth (DepthUsed)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (RecW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctit_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (out_push),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_free)
    else $error("result pushed into a full output register");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(DepthUsed))
    else $error("alive count beyond table size");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && res.last) |=> (state_q == StIdle))
    else $error("final result without return to idle");
  a_session_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    session_q != 30'd0)
    else $error("session counter reached zero");
`endif

endmodule

FILE: tb/sv/connection_table_checker.sv
`timescale 1ns / 100ps

module connection_table_checker
  import ctit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  localparam int unsigned Slots = 32;

  entry_t      rec [Slots];
  logic        live [Slots];
  logic [31:0] now_s;
  logic [29:0] next_session;
  logic [5:0]  active_cfg;
  out_t        replies_q [$];

  function automatic out_t pack_result(logic [1:0] kind, logic status, logic [4:0] idx,
                                       logic [29:0] sess, logic [31:0] sock,
                                       logic [5:0] cnt, logic fin);
    out_t r;
    r.kind           = kind;
    r.status         = status;
    r.result_index   = idx;
    r.result_session = sess;
    r.result_socket  = sock;
    r.alive_count    = cnt;
    r.last           = fin;
    return r;
  endfunction

  function automatic int unsigned table_len();
    return (32'(active_cfg) > Slots) ? Slots : 32'(active_cfg);
  endfunction

  task automatic drop_entry(input int unsigned i);
    live[i] = 1'b0;
    rec[i]  = '0;
  endtask

  // session 0 is never handed out, so it can never match
  function automatic logic owns(in_t it);
    return live[it.entry_index] && rec[it.entry_index].socket == it.socket_id &&
           it.session_id != '0 && rec[it.entry_index].session == it.session_id;
  endfunction

  task automatic forecast(input in_t it);
    int unsigned n;
    int unsigned cnt;
    int unsigned found;
    logic [1:0]  kind;
    logic        expired;
    logic [31:0] idle_s;
    n = table_len();
    if (it.cmd == CmdAdd) begin
      found = n;
      for (int unsigned i = 0; i < n; i++)
        if (!live[i] && found == n) found = i;
      if (found < n) begin
        live[found]          = 1'b1;
        rec[found].socket    = it.socket_id;
        rec[found].session   = next_session;
        rec[found].chk_send  = it.check_send;
        rec[found].chk_recv  = it.check_receive;
        rec[found].send_lim  = it.send_timeout;
        rec[found].recv_lim  = it.receive_timeout;
        rec[found].last_send = now_s;
        rec[found].last_recv = now_s;
        replies_q.push_back(pack_result(KindReply, 1'b0, 5'(found), next_session,
                                        it.socket_id, '0, 1'b1));
        next_session = (next_session > SessionTop) ? 30'd1 : next_session + 30'd1;
      end else begin
        replies_q.push_back(pack_result(KindReply, 1'b1, '0, '0, it.socket_id, '0, 1'b1));
      end
    end else if (it.cmd == CmdTick) begin
      now_s = now_s + 32'd1;
      cnt = 0;
      for (int unsigned i = 0; i < n; i++)
        if (live[i]) cnt++;
      for (int unsigned i = 0; i < n; i++) begin
        if (live[i]) begin
          expired = 1'b0;
          idle_s = now_s - rec[i].last_send;
          if (rec[i].chk_send && idle_s > {16'd0, rec[i].send_lim}) begin
            kind = KindSendExp;
            expired = 1'b1;
          end else begin
            idle_s = now_s - rec[i].last_recv;
            if (rec[i].chk_recv && idle_s > {16'd0, rec[i].recv_lim}) begin
              kind = KindRecvExp;
              expired = 1'b1;
            end
          end
          if (expired) begin
            replies_q.push_back(pack_result(kind, 1'b0, 5'(i), rec[i].session,
                                            rec[i].socket, '0, 1'b0));
            drop_entry(i);
          end
        end
      end
      replies_q.push_back(pack_result(KindSummary, 1'b0, '0, '0, it.socket_id, 6'(cnt),
                                      1'b1));
    end else if (it.cmd > CmdTick || it.entry_index >= n) begin
      replies_q.push_back(pack_result(KindReply, 1'b1, '0, '0, it.socket_id, '0, 1'b1));
    end else if (it.cmd == CmdClose) begin
      // close never reports a mismatch
      if (owns(it)) drop_entry(it.entry_index);
      replies_q.push_back(pack_result(KindReply, 1'b0, '0, '0, it.socket_id, '0, 1'b1));
    end else if (!owns(it)) begin
      replies_q.push_back(pack_result(KindReply, 1'b1, '0, '0, it.socket_id, '0, 1'b1));
    end else begin
      case (it.cmd)
        CmdDelete: begin
          drop_entry(it.entry_index);
        end
        CmdSetSend: begin
          if (it.check_send) begin
            rec[it.entry_index].last_send = now_s;
            rec[it.entry_index].send_lim  = it.send_timeout;
          end
          rec[it.entry_index].chk_send = it.check_send;
        end
        default: begin
          if (it.check_receive) begin
            rec[it.entry_index].last_recv = now_s;
            rec[it.entry_index].recv_lim  = it.receive_timeout;
          end
          rec[it.entry_index].chk_recv = it.check_receive;
        end
      endcase
      replies_q.push_back(pack_result(KindReply, 1'b0, '0, '0, it.socket_id, '0, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (replies_q.size() == 0) begin
      $display("%0t: unexpected result item, expected none, actual %h", $time, got);
      fail_count_o++;
    end else begin
      want = replies_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("result_index", 32'(want.result_index), 32'(got.result_index));
      check_field("result_session", 32'(want.result_session), 32'(got.result_session));
      check_field("result_socket", want.result_socket, got.result_socket);
      check_field("alive_count", 32'(want.alive_count), 32'(got.alive_count));
      check_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < Slots; i++) drop_entry(i);
      now_s         = '0;
      next_session  = 30'd1;
      active_cfg    = ActiveRst;
      replies_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) forecast(in_data_i);
      if (cfg_we_i) active_cfg = cfg_data_i;
      outstanding_o = replies_q.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ctit_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 36;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned Phases       = 7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_t         in_data_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [5:0]  cfg_data_i  = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_t        out_data_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles = 0;
  logic        calm   = 1'b0;

  // connections the stimulus believes are open, learnt from the replies
  logic        known_live [32];
  logic [31:0] known_sock [32];
  logic [29:0] known_sess [32];

  logic [5:0]  phase_cfg [Phases] = '{6'd5, 6'd32, 6'd1, 6'd12, 6'd63, 6'd3, 6'd32};

  connection_idle_timeout_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  connection_table_checker table_watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99, 0) >= 30);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (out_data_o.kind == KindReply && !out_data_o.status &&
          out_data_o.result_session != '0) begin
        known_live[out_data_o.result_index] = 1'b1;
        known_sock[out_data_o.result_index] = out_data_o.result_socket;
        known_sess[out_data_o.result_index] = out_data_o.result_session;
      end else if (out_data_o.kind == KindSendExp || out_data_o.kind == KindRecvExp) begin
        known_live[out_data_o.result_index] = 1'b0;
      end
    end
  end

  function automatic in_t build(logic [2:0] c, logic [31:0] sock, logic [29:0] sess,
                                logic [4:0] idx, logic cs, logic cr,
                                logic [15:0] st, logic [15:0] rt);
    in_t it;
    it.cmd             = c;
    it.socket_id       = sock;
    it.session_id      = sess;
    it.entry_index     = idx;
    it.check_send      = cs;
    it.check_receive   = cr;
    it.send_timeout    = st;
    it.receive_timeout = rt;
    return it;
  endfunction

  function automatic in_t aimed(logic [2:0] c, logic [4:0] idx, logic cs, logic cr,
                                logic [15:0] st, logic [15:0] rt);
    return build(c, known_sock[idx], known_sess[idx], idx, cs, cr, st, rt);
  endfunction

  function automatic logic [29:0] rnd_session();
    return 30'($urandom_range(1000000000, 0));
  endfunction

  function automatic in_t noise(logic [2:0] c);
    return build(c, $urandom, rnd_session(), 5'($urandom_range(31, 0)),
                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                 16'($urandom), 16'($urandom));
  endfunction

  task automatic send_item(input in_t it);
    while (!calm && $urandom_range(99, 0) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic set_active(input logic [5:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // adds, ticks and commands aimed at open connections, the rest near misses and noise
  task automatic random_order(output in_t it);
    int unsigned pick;
    int unsigned slot;
    int          live_idx [$];
    logic [2:0]  c;
    logic [15:0] st;
    logic [15:0] rt;
    pick = $urandom_range(99, 0);
    st = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(6, 0));
    rt = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(6, 0));
    if (pick < 22) begin
      it = noise(CmdAdd);
      it.send_timeout    = st;
      it.receive_timeout = rt;
    end else if (pick < 42) begin
      it = noise(CmdTick);
    end else if (pick < 90) begin
      if (pick < 54) c = CmdDelete;
      else if (pick < 66) c = CmdSetSend;
      else if (pick < 78) c = CmdSetRecv;
      else c = CmdClose;
      for (int i = 0; i < 32; i++)
        if (known_live[i]) live_idx.push_back(i);
      if (live_idx.size() == 0 || $urandom_range(99, 0) < 12) begin
        it = noise(c);
      end else begin
        slot = live_idx[$urandom_range(live_idx.size() - 1, 0)];
        it = aimed(c, 5'(slot), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), st, rt);
        if ($urandom_range(99, 0) < 10) begin
          it.socket_id = it.socket_id ^ (32'd1 << $urandom_range(31, 0));
        end else if (c == CmdDelete || c == CmdClose) begin
          known_live[slot] = 1'b0;
        end
      end
    end else if (pick < 94) begin
      it = noise(($urandom_range(1, 0) == 0) ? 3'd6 : 3'd7);
    end else begin
      it = noise(3'($urandom_range(7, 0)));
    end
  endtask

  initial begin
    in_t it;
    for (int i = 0; i < 32; i++) begin
      known_live[i] = 1'b0;
      known_sock[i] = '0;
      known_sess[i] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: full table in use
    send_item(build(CmdAdd, 32'hFFFF_FFFF, 30'd1000000000, 5'd31, 1'b1, 1'b1, '0, '0));
    send_item(build(CmdAdd, '0, '0, '0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
    send_item(build(CmdAdd, $urandom, rnd_session(), '0, 1'b0, 1'b1, '0, '0));
    send_item(build(CmdAdd, $urandom, rnd_session(), '0, 1'b1, 1'b1, 16'hFFFF, 16'd1));
    drain();
    send_item(build(CmdDelete, known_sock[1], '0, 5'd1, 1'b0, 1'b0, '0, '0));
    send_item(build(CmdSetSend, known_sock[1], '0, 5'd1, 1'b1, 1'b0, '0, '0));
    send_item(build(CmdClose, ~known_sock[1], known_sess[1], 5'd1, 1'b0, 1'b0, '0, '0));
    send_item(build(CmdDelete, $urandom, rnd_session(), 5'd31, 1'b0, 1'b0, '0, '0));
    send_item(aimed(CmdSetSend, 5'd1, 1'b1, 1'b0, '0, 16'hFFFF));
    send_item(aimed(CmdSetRecv, 5'd3, 1'b1, 1'b0, '0, '0));
    send_item(noise(3'd6));
    send_item(noise(3'd7));
    send_item(noise(CmdTick));
    drain();
    send_item(aimed(CmdClose, 5'd3, 1'b0, 1'b0, '0, '0));
    send_item(aimed(CmdDelete, 5'd3, 1'b0, 1'b0, '0, '0));
    send_item(noise(CmdTick));

    // two entries: full table, then an index past the end
    set_active(6'd2);
    send_item(build(CmdAdd, $urandom, '0, '0, 1'b1, 1'b0, 16'd2, '0));
    send_item(build(CmdAdd, $urandom, '0, '0, 1'b0, 1'b1, '0, 16'd3));
    send_item(build(CmdAdd, $urandom, '0, '0, 1'b1, 1'b1, '0, '0));
    send_item(build(CmdDelete, $urandom, rnd_session(), 5'd5, 1'b0, 1'b0, '0, '0));
    send_item(noise(CmdTick));

    // empty table, then a value past the table size
    set_active(6'd0);
    send_item(noise(CmdAdd));
    send_item(aimed(CmdClose, 5'd0, 1'b0, 1'b0, '0, '0));
    send_item(noise(CmdTick));
    set_active(6'd63);
    send_item(noise(CmdTick));

    for (int p = 0; p < Phases; p++) begin
      set_active(phase_cfg[p]);
      calm = (p == 1);
      for (int k = 0; k < PhaseItems; k++) begin
        random_order(it);
        send_item(it);
      end
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ctit_pkg.sv
hw/rtl/ctit_ram.sv
hw/rtl/ctit_out_reg.sv
hw/rtl/connection_idle_timeout_table_unit.sv
tb/sv/connection_table_checker.sv
tb/sv/testbench.sv
